### rtl/ebv_pkg.sv
// Shared types, constants and helpers for the EBV varint codec.
package ebv_pkg;

  // Field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned GroupW = 7;
  localparam int unsigned AccW   = 28;
  localparam int unsigned PosW   = 3;
  localparam int unsigned LenW   = 3;

  // Byte format
  localparam logic [ByteW-1:0] ContBit = 8'h80;
  localparam logic [PosW-1:0]  MaxBytes = 3'd5;
  localparam logic [PosW-1:0]  LastIdx  = 3'd4;

  // Length thresholds
  localparam logic [ValueW-1:0] Max1 = 32'h0000_007f;
  localparam logic [ValueW-1:0] Max2 = 32'h0000_3fff;
  localparam logic [ValueW-1:0] Max3 = 32'h001f_ffff;
  localparam logic [ValueW-1:0] Max4 = 32'h0fff_ffff;

  typedef enum logic {
    CmdEncode = 1'b0,
    CmdDecode = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StEncByte  = 2'd0,
    StDecDone  = 2'd1,
    StDecTrunc = 2'd2
  } status_e;

  // One result beat
  typedef struct packed {
    status_e             status;
    logic [ByteW-1:0]    out_byte;
    logic [ValueW-1:0]   decoded_value;
    logic [LenW-1:0]     length;
    logic                last;
  } result_t;

  // Decoder running state
  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [AccW-1:0] acc;
  } dec_state_t;

  // Smallest byte count that holds v
  function automatic logic [LenW-1:0] encoded_length(input logic [ValueW-1:0] v);
    logic [LenW-1:0] len;
    if (v <= Max1)      len = 3'd1;
    else if (v <= Max2) len = 3'd2;
    else if (v <= Max3) len = 3'd3;
    else if (v <= Max4) len = 3'd4;
    else                len = MaxBytes;
    return len;
  endfunction

endpackage

### rtl/ebv_beat_gen.sv
// Per-beat result logic: one encoded byte or one decode step.
module ebv_beat_gen (
  input  logic                        command_i,
  input  logic [31:0]                 value_i,
  input  logic [7:0]                  data_byte_i,
  input  logic                        end_of_buffer_i,
  input  logic [2:0]                  beat_idx_i,
  input  ebv_pkg::dec_state_t         dec_q_i,
  output logic                        res_valid_o,
  output ebv_pkg::result_t            res_o,
  output ebv_pkg::dec_state_t         dec_d_o
);
  import ebv_pkg::*;

  logic [LenW-1:0]   enc_len;
  logic [ByteW-1:0]  enc_byte;
  logic [GroupW-1:0] grp;
  logic              enc_more;
  logic [AccW-1:0]   acc_shift;
  logic [AccW-1:0]   acc_new;
  logic [GroupW-1:0] dbits;

  // Encoder: pick the 7-bit group for this beat
  always_comb begin
    enc_len  = encoded_length(value_i);
    enc_more = ({1'b0, beat_idx_i} + 4'd1) < {1'b0, enc_len};
    case (beat_idx_i)
      3'd0:    grp = value_i[6:0];
      3'd1:    grp = value_i[13:7];
      3'd2:    grp = value_i[20:14];
      3'd3:    grp = value_i[27:21];
      default: grp = '0;
    endcase
    if (beat_idx_i >= LastIdx) begin
      enc_byte = {4'b0, value_i[31:28]};
    end else begin
      enc_byte = {1'b0, grp} | (enc_more ? ContBit : '0);
    end
  end

  // Decoder: merge this byte's group into the accumulator
  always_comb begin
    dbits = data_byte_i[6:0];
    case (dec_q_i.pos)
      3'd0:    acc_shift = {21'b0, dbits};
      3'd1:    acc_shift = {14'b0, dbits, 7'b0};
      3'd2:    acc_shift = {7'b0, dbits, 14'b0};
      3'd3:    acc_shift = {dbits, 21'b0};
      default: acc_shift = '0;
    endcase
    acc_new = dec_q_i.acc | acc_shift;
  end

  always_comb begin
    res_valid_o = 1'b1;
    res_o       = '0;
    dec_d_o     = dec_q_i;
    if (command_i == CmdEncode) begin
      res_o.status   = StEncByte;
      res_o.out_byte = enc_byte;
      res_o.length   = enc_len;
      res_o.last     = !enc_more;
    end else if (dec_q_i.pos >= LastIdx) begin
      // fifth byte always closes the vector
      res_o.status        = StDecDone;
      res_o.decoded_value = {data_byte_i[3:0], dec_q_i.acc};
      res_o.length        = MaxBytes;
      res_o.last          = 1'b1;
      dec_d_o             = '0;
    end else if (!data_byte_i[7]) begin
      res_o.status        = StDecDone;
      res_o.decoded_value = {4'b0, acc_new};
      res_o.length        = dec_q_i.pos + 3'd1;
      res_o.last          = 1'b1;
      dec_d_o             = '0;
    end else if (end_of_buffer_i) begin
      // continuation on the last available byte
      res_o.status = StDecTrunc;
      res_o.last   = 1'b1;
      dec_d_o      = '0;
    end else begin
      res_valid_o = 1'b0;
      dec_d_o.pos = dec_q_i.pos + 3'd1;
      dec_d_o.acc = acc_new;
    end
  end

endmodule

### rtl/ebv_varint_codec.sv
// Top level of the EBV varint encoder/decoder.
//
//   channel | direction | beat contents
//   --------+-----------+------------------------------------------------
//   in      | input     | command, value, data_byte, end_of_buffer
//   out     | output    | status, out_byte, decoded_value, length, last
//
// Decode bytes stream in at one per cycle while out is not stalled.
// An encode command holds the input register until its 1 to 5 bytes have
// gone to the output register, one byte per beat.
// Reset clears the decoder position and accumulator and empties both stages.
// A stall on out holds the output register; input is taken while it waits
// as long as the input register is free.
module ebv_varint_codec (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [31:0] value_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  out_byte_o,
  output logic [31:0] decoded_value_o,
  output logic [2:0]  length_o,
  output logic        last_o
);
  import ebv_pkg::*;

  // input stage
  logic              s1_valid_q, s1_valid_d;
  logic              cmd_q;
  logic [ValueW-1:0] value_q;
  logic [ByteW-1:0]  byte_q;
  logic              eob_q;
  logic [PosW-1:0]   idx_q, idx_d;

  // decoder state
  dec_state_t dec_q, dec_d, dec_next;

  // output stage
  logic    out_valid_q, out_valid_d;
  result_t res_q, res;
  logic    res_valid;

  logic can_load, beat_fire, s1_done, in_fire;

  ebv_beat_gen u_beat_gen (
    .command_i       (cmd_q),
    .value_i         (value_q),
    .data_byte_i     (byte_q),
    .end_of_buffer_i (eob_q),
    .beat_idx_i      (idx_q),
    .dec_q_i         (dec_q),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .dec_d_o         (dec_next)
  );

  // handshake between stages
  always_comb begin
    can_load    = !out_valid_q || out_ready_i;
    beat_fire   = s1_valid_q && res_valid && can_load;
    s1_done     = s1_valid_q && (!res_valid || (can_load && res.last));
    in_ready_o  = !s1_valid_q || s1_done;
    in_fire     = in_valid_i && in_ready_o;

    s1_valid_d  = in_fire ? 1'b1 : (s1_done ? 1'b0 : s1_valid_q);
    if (in_fire)        idx_d = '0;
    else if (beat_fire) idx_d = idx_q + 3'd1;
    else                idx_d = idx_q;

    dec_d       = s1_done ? dec_next : dec_q;
    out_valid_d = beat_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      idx_q       <= '0;
      dec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      idx_q       <= idx_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= command_i;
      value_q <= value_i;
      byte_q  <= data_byte_i;
      eob_q   <= end_of_buffer_i;
    end
    if (beat_fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign out_byte_o      = res_q.out_byte;
  assign decoded_value_o = res_q.decoded_value;
  assign length_o        = res_q.length;
  assign last_o          = res_q.last;

endmodule
